/* hdl/pse_pkg.sv */
// Shared types, constants, CRC-32 and byte-select helpers of the PNG stored-block encoder.
// No dependencies; imported by pse_cfg, pse_gen, the top level and the testbench.
`default_nettype none

package pse_pkg;

    localparam int MAX_DIMENSION    = 8192;
    localparam int DIM_W            = 14;
    localparam int COUNT_W          = 13;
    localparam int BLOCK_LEN_W      = 16;
    localparam int STORED_BLOCK_MAX = (1 << BLOCK_LEN_W) - 1;
    localparam int RAW_W            = 28;
    localparam int BLOCKS_W         = RAW_W - BLOCK_LEN_W + 1;
    localparam int RESULT_LIMIT     = 52;
    localparam int BUDGET_W         = 6;

    localparam logic [31:0] CRC_POLY      = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT      = 32'hFFFFFFFF;
    localparam logic [16:0] ADLER_MOD     = 17'd65521;
    localparam logic [63:0] PNG_SIGNATURE = 64'h89504E470D0A1A0A;
    localparam logic [31:0] TYPE_IHDR     = 32'h49484452;
    localparam logic [31:0] TYPE_IDAT     = 32'h49444154;
    localparam logic [31:0] TYPE_IEND     = 32'h49454E44;
    localparam logic [31:0] IHDR_LENGTH   = 32'd13;
    localparam logic [7:0]  ZLIB_CMF      = 8'h78;
    localparam logic [7:0]  ZLIB_FLG      = 8'h01;
    localparam logic [7:0]  BIT_DEPTH     = 8'd8;
    localparam logic [7:0]  COLOR_TYPE    = 8'd2;

    typedef enum logic [1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1
    } t_cfg_index;

    typedef enum logic [1:0] {
        PH_START,
        PH_STREAM,
        PH_DONE
    } t_phase;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SIG,
        S_IHDR_LEN,
        S_IHDR_TYPE,
        S_IHDR_DATA,
        S_IHDR_CRC,
        S_IDAT_LEN,
        S_IDAT_TYPE,
        S_ZHDR,
        S_DATA,
        S_ADLER,
        S_IDAT_CRC,
        S_IEND_LEN,
        S_IEND_TYPE,
        S_IEND_CRC
    } t_sec;

    typedef enum logic [1:0] {
        D_FILTER,
        D_RED,
        D_GREEN,
        D_BLUE
    } t_dsel;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [RAW_W-1:0] raw;
        logic [31:0]      idat_len;
    } t_geom;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       eof;
    } t_out_beat;

    typedef struct packed {
        logic step_open;
        logic drop;
        logic job_fin;
    } t_gen_stat;

    function automatic logic [31:0] crc_update(input logic [31:0] crc, input logic [7:0] data);
        logic [31:0] c;
        c = crc ^ {24'd0, data};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [7:0] word_byte(input logic [31:0] word, input logic [1:0] sel);
        logic [7:0] b;
        case (sel)
            2'd0:    b = word[31:24];
            2'd1:    b = word[23:16];
            2'd2:    b = word[15:8];
            default: b = word[7:0];
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

/* hdl/png_stored_block_encoder_unit.sv */
// Top level of the PNG stored-block encoder: pixel buffer, output register, assertions.
// Depends on pse_pkg, pse_cfg and pse_gen.
//
// Pixels (24-bit RGB, raster order) arrive on i_in_valid / o_in_stall; file bytes
// leave on o_out_valid / i_out_stall, one byte per transfer. The first pixel of a
// file produces the signature, IHDR, the IDAT header, the zlib header and the first
// stored-block header ahead of its own data; the last pixel appends Adler-32, the
// IDAT CRC and IEND, with o_end_of_file on the final byte. o_last_of_run marks the
// last byte of each pixel's run; a run is cut at 52 bytes and the rest goes out
// with the next pixel, which is then dropped.
// Throughput: one output byte per cycle while the receiver does not stall, set by the
// single byte lane of the sequencer. Each pixel's run goes from the pixel buffer
// through the sequencer's job registers to the output register. A one-entry pixel buffer
// takes the next pixel while bytes are still in flight.
// Reset (synchronous, active low) returns both dimensions to 1 and the sequencer
// to idle. A stalled receiver freezes the sequencer; the output byte holds.
// A write to either dimension register abandons any file in progress.
`default_nettype none

module png_stored_block_encoder_unit
    import pse_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [1:0]        i_cfg_idx,
    input  wire logic [DIM_W-1:0]  i_cfg_data,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [23:0]       i_pixel_rgb,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [7:0]             o_out_byte,
    output logic                   o_last_of_run,
    output logic                   o_end_of_file
);

    t_geom       geom;
    logic        abort;
    logic        pix_take;
    logic        beat_valid;
    t_out_beat   beat;
    t_gen_stat   stat;
    logic        out_ready;

    logic        r_pix_valid;
    logic [23:0] r_pix;
    logic        r_out_valid;
    t_out_beat   r_out;

    pse_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_geom     (geom),
        .o_abort    (abort)
    );

    pse_gen u_gen (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_geom       (geom),
        .i_abort      (abort),
        .i_pix_valid  (r_pix_valid),
        .i_pix        (r_pix),
        .i_out_ready  (out_ready),
        .o_pix_take   (pix_take),
        .o_beat_valid (beat_valid),
        .o_beat       (beat),
        .o_stat       (stat)
    );

    assign o_in_stall = r_pix_valid;
    assign out_ready  = !r_out_valid || !i_out_stall;

    // hold one pixel until the sequencer takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix_valid <= 1'b0;
        end else if (i_in_valid && !r_pix_valid) begin
            r_pix_valid <= 1'b1;
        end else if (pix_take) begin
            r_pix_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !r_pix_valid) begin
            r_pix <= i_pixel_rgb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (beat_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (beat_valid) begin
            r_out <= beat;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out.data;
    assign o_last_of_run = r_out.last;
    assign o_end_of_file = r_out.eof;

    a_eof_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_end_of_file |-> o_last_of_run)
        else $error("end of file not at end of run");

    a_abort_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we && (i_cfg_idx == CFG_WIDTH || i_cfg_idx == CFG_HEIGHT)
        |=> !stat.step_open)
        else $error("run still open after dimension write");

    a_drop_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.drop |-> stat.job_fin)
        else $error("pixel dropped while file not complete");

    a_take_needs_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pix_take |-> r_pix_valid)
        else $error("pixel taken from empty buffer");

endmodule

`default_nettype wire

/* hdl/pse_cfg.sv */
// Dimension registers and image size pipeline (raw length, block count, IDAT length).
// Depends on pse_pkg.
`default_nettype none

module pse_cfg
    import pse_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [1:0]        i_cfg_idx,
    input  wire logic [DIM_W-1:0]  i_cfg_data,
    output t_geom                  o_geom,
    output logic                   o_abort
);

    logic [DIM_W-1:0]    r_width;
    logic [DIM_W-1:0]    r_height;
    logic [RAW_W-1:0]    r_raw;
    logic [BLOCKS_W-1:0] r_blocks;
    logic [31:0]         r_idat_len;

    logic [DIM_W-1:0]    eff;
    logic [15:0]         row_len;
    logic [29:0]         product;
    logic [BLOCK_LEN_W:0] fold;
    logic                fold_ge;
    logic [BLOCK_LEN_W:0] fold_rem;
    logic [BLOCKS_W-1:0] n_blocks;
    logic [31:0]         n_idat_len;

    always_comb begin
        if (i_cfg_data == '0) begin
            eff = DIM_W'(1);
        end else if (i_cfg_data > DIM_W'(MAX_DIMENSION)) begin
            eff = DIM_W'(MAX_DIMENSION);
        end else begin
            eff = i_cfg_data;
        end
    end

    always_comb begin
        o_abort = 1'b0;
        case (t_cfg_index'(i_cfg_idx))
            CFG_WIDTH:  o_abort = i_cfg_we;
            CFG_HEIGHT: o_abort = i_cfg_we;
            default:    o_abort = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_W'(1);
            r_height <= DIM_W'(1);
        end else if (i_cfg_we && t_cfg_index'(i_cfg_idx) == CFG_WIDTH) begin
            r_width <= eff;
        end else if (i_cfg_we && t_cfg_index'(i_cfg_idx) == CFG_HEIGHT) begin
            r_height <= eff;
        end
    end

    assign row_len  = 16'({r_width, 1'b0}) + 16'(r_width) + 16'd1;
    assign product  = row_len * 30'(r_height);

    assign fold     = (BLOCK_LEN_W+1)'(r_raw[RAW_W-1:BLOCK_LEN_W])
                    + (BLOCK_LEN_W+1)'(r_raw[BLOCK_LEN_W-1:0]);
    assign fold_ge  = fold >= (BLOCK_LEN_W+1)'(STORED_BLOCK_MAX);
    assign fold_rem = fold_ge ? fold - (BLOCK_LEN_W+1)'(STORED_BLOCK_MAX) : fold;
    assign n_blocks = BLOCKS_W'(r_raw[RAW_W-1:BLOCK_LEN_W]) + BLOCKS_W'(fold_ge)
                    + BLOCKS_W'(fold_rem != '0);
    assign n_idat_len = 32'(r_raw) + 32'({r_blocks, 2'b00}) + 32'(r_blocks) + 32'd6;

    always_ff @(posedge i_clk) begin
        r_raw      <= product[RAW_W-1:0];
        r_blocks   <= n_blocks;
        r_idat_len <= n_idat_len;
    end

    assign o_geom.width    = r_width;
    assign o_geom.height   = r_height;
    assign o_geom.raw      = r_raw;
    assign o_geom.idat_len = r_idat_len;

endmodule

`default_nettype wire

/* hdl/pse_gen.sv */
// Byte sequencer: walks file sections, inserts stored-block headers, keeps CRC-32 and Adler-32.
// Depends on pse_pkg; geometry comes from pse_cfg.
`default_nettype none

module pse_gen
    import pse_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_geom       i_geom,
    input  wire logic        i_abort,
    input  wire logic        i_pix_valid,
    input  wire logic [23:0] i_pix,
    input  wire logic        i_out_ready,
    output logic             o_pix_take,
    output logic             o_beat_valid,
    output t_out_beat        o_beat,
    output t_gen_stat        o_stat
);

    t_sec                   r_state, n_state;
    t_dsel                  r_dsel, n_dsel;
    t_phase                 r_phase, n_phase;
    logic [3:0]             r_idx, n_idx;
    logic                   r_open, n_open;
    logic [BUDGET_W-1:0]    r_budget, n_budget;
    logic [31:0]            r_crc, n_crc;
    logic [15:0]            r_adler_lo, n_adler_lo;
    logic [15:0]            r_adler_hi, n_adler_hi;
    logic [BLOCK_LEN_W-1:0] r_block_left, n_block_left;
    logic [RAW_W-1:0]       r_raw_left, n_raw_left;
    logic [COUNT_W-1:0]     r_col, n_col;
    logic [COUNT_W-1:0]     r_row, n_row;
    logic [23:0]            r_job_pix, n_job_pix;
    logic                   r_job_fin, n_job_fin;

    t_sec                   seq_state;
    logic [3:0]             seq_idx;
    t_dsel                  seq_dsel;
    logic                   emit;
    logic [7:0]             byte_out;
    logic                   crc_en, crc_init, data_en, eof, job_end;
    logic                   step_last, closing, step_start, held, job_start;
    logic [BLOCK_LEN_W-1:0] blk_len;
    logic                   blk_final;
    logic [63:0]            sig_shift;
    logic [16:0]            lo_sum, hi_sum;
    logic [15:0]            lo_next, hi_next;
    logic                   sf, wrap, fin;
    logic [COUNT_W-1:0]     col0, row0;
    logic [COUNT_W:0]       col_inc, row_inc;

    assign emit    = r_open && i_out_ready;
    assign blk_len = (r_raw_left > RAW_W'(STORED_BLOCK_MAX)) ? BLOCK_LEN_W'(STORED_BLOCK_MAX)
                                                             : r_raw_left[BLOCK_LEN_W-1:0];
    assign blk_final = RAW_W'(blk_len) == r_raw_left;
    assign sig_shift = PNG_SIGNATURE >> {3'd7 - r_idx[2:0], 3'b000};

    always_comb begin
        byte_out  = '0;
        crc_en    = 1'b0;
        crc_init  = 1'b0;
        data_en   = 1'b0;
        eof       = 1'b0;
        job_end   = 1'b0;
        seq_state = r_state;
        seq_idx   = r_idx + 4'd1;
        seq_dsel  = r_dsel;
        case (r_state)
            S_SIG: begin
                byte_out = sig_shift[7:0];
                if (r_idx == 4'd7) begin
                    seq_state = S_IHDR_LEN;
                    seq_idx   = '0;
                end
            end
            S_IHDR_LEN: begin
                byte_out = word_byte(IHDR_LENGTH, r_idx[1:0]);
                if (r_idx == 4'd3) begin
                    seq_state = S_IHDR_TYPE;
                    seq_idx   = '0;
                end
            end
            S_IHDR_TYPE: begin
                byte_out = word_byte(TYPE_IHDR, r_idx[1:0]);
                crc_en   = 1'b1;
                crc_init = r_idx == '0;
                if (r_idx == 4'd3) begin
                    seq_state = S_IHDR_DATA;
                    seq_idx   = '0;
                end
            end
            S_IHDR_DATA: begin
                crc_en = 1'b1;
                if (r_idx < 4'd4) begin
                    byte_out = word_byte(32'(i_geom.width), r_idx[1:0]);
                end else if (r_idx < 4'd8) begin
                    byte_out = word_byte(32'(i_geom.height), r_idx[1:0]);
                end else if (r_idx == 4'd8) begin
                    byte_out = BIT_DEPTH;
                end else if (r_idx == 4'd9) begin
                    byte_out = COLOR_TYPE;
                end
                if (r_idx == 4'd12) begin
                    seq_state = S_IHDR_CRC;
                    seq_idx   = '0;
                end
            end
            S_IHDR_CRC: begin
                byte_out = word_byte(~r_crc, r_idx[1:0]);
                if (r_idx == 4'd3) begin
                    seq_state = S_IDAT_LEN;
                    seq_idx   = '0;
                end
            end
            S_IDAT_LEN: begin
                byte_out = word_byte(i_geom.idat_len, r_idx[1:0]);
                if (r_idx == 4'd3) begin
                    seq_state = S_IDAT_TYPE;
                    seq_idx   = '0;
                end
            end
            S_IDAT_TYPE: begin
                byte_out = word_byte(TYPE_IDAT, r_idx[1:0]);
                crc_en   = 1'b1;
                crc_init = r_idx == '0;
                if (r_idx == 4'd3) begin
                    seq_state = S_ZHDR;
                    seq_idx   = '0;
                end
            end
            S_ZHDR: begin
                byte_out = (r_idx == '0) ? ZLIB_CMF : ZLIB_FLG;
                crc_en   = 1'b1;
                if (r_idx == 4'd1) begin
                    seq_state = S_DATA;
                    seq_idx   = '0;
                    seq_dsel  = D_FILTER;
                end
            end
            S_DATA: begin
                crc_en = 1'b1;
                if (r_block_left == '0) begin
                    case (r_idx)
                        4'd0:    byte_out = {7'd0, blk_final};
                        4'd1:    byte_out = blk_len[7:0];
                        4'd2:    byte_out = blk_len[15:8];
                        4'd3:    byte_out = ~blk_len[7:0];
                        default: byte_out = ~blk_len[15:8];
                    endcase
                    if (r_idx == 4'd4) begin
                        seq_idx = '0;
                    end
                end else begin
                    data_en = 1'b1;
                    seq_idx = '0;
                    case (r_dsel)
                        D_FILTER: byte_out = 8'd0;
                        D_RED:    byte_out = r_job_pix[23:16];
                        D_GREEN:  byte_out = r_job_pix[15:8];
                        default:  byte_out = r_job_pix[7:0];
                    endcase
                    if (r_dsel == D_BLUE) begin
                        if (r_job_fin) begin
                            seq_state = S_ADLER;
                        end else begin
                            seq_state = S_IDLE;
                            job_end   = 1'b1;
                        end
                    end else begin
                        seq_dsel = t_dsel'(r_dsel + 2'd1);
                    end
                end
            end
            S_ADLER: begin
                byte_out = word_byte({r_adler_hi, r_adler_lo}, r_idx[1:0]);
                crc_en   = 1'b1;
                if (r_idx == 4'd3) begin
                    seq_state = S_IDAT_CRC;
                    seq_idx   = '0;
                end
            end
            S_IDAT_CRC: begin
                byte_out = word_byte(~r_crc, r_idx[1:0]);
                if (r_idx == 4'd3) begin
                    seq_state = S_IEND_LEN;
                    seq_idx   = '0;
                end
            end
            S_IEND_LEN: begin
                byte_out = 8'd0;
                if (r_idx == 4'd3) begin
                    seq_state = S_IEND_TYPE;
                    seq_idx   = '0;
                end
            end
            S_IEND_TYPE: begin
                byte_out = word_byte(TYPE_IEND, r_idx[1:0]);
                crc_en   = 1'b1;
                crc_init = r_idx == '0;
                if (r_idx == 4'd3) begin
                    seq_state = S_IEND_CRC;
                    seq_idx   = '0;
                end
            end
            S_IEND_CRC: begin
                byte_out = word_byte(~r_crc, r_idx[1:0]);
                if (r_idx == 4'd3) begin
                    eof       = 1'b1;
                    job_end   = 1'b1;
                    seq_state = S_IDLE;
                    seq_idx   = '0;
                end
            end
            default: begin
                seq_idx = r_idx;
            end
        endcase
    end

    assign lo_sum  = {1'b0, r_adler_lo} + 17'(byte_out);
    assign lo_next = (lo_sum >= ADLER_MOD) ? 16'(lo_sum - ADLER_MOD) : lo_sum[15:0];
    assign hi_sum  = {1'b0, r_adler_hi} + {1'b0, lo_next};
    assign hi_next = (hi_sum >= ADLER_MOD) ? 16'(hi_sum - ADLER_MOD) : hi_sum[15:0];

    assign step_last  = job_end || (r_budget == BUDGET_W'(RESULT_LIMIT - 1));
    assign closing    = emit && step_last;
    assign step_start = i_pix_valid && (!r_open || closing);
    assign held       = r_open ? (seq_state != S_IDLE) : (r_state != S_IDLE);
    assign job_start  = step_start && !held;

    assign sf      = r_phase != PH_STREAM;
    assign col0    = sf ? '0 : r_col;
    assign row0    = sf ? '0 : r_row;
    assign col_inc = {1'b0, col0} + (COUNT_W+1)'(1);
    assign row_inc = {1'b0, row0} + (COUNT_W+1)'(1);
    assign wrap    = col_inc >= i_geom.width;
    assign fin     = wrap && (row_inc >= i_geom.height);

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_dsel       = r_dsel;
        n_phase      = r_phase;
        n_open       = r_open;
        n_budget     = r_budget;
        n_crc        = r_crc;
        n_adler_lo   = r_adler_lo;
        n_adler_hi   = r_adler_hi;
        n_block_left = r_block_left;
        n_raw_left   = r_raw_left;
        n_col        = r_col;
        n_row        = r_row;
        n_job_pix    = r_job_pix;
        n_job_fin    = r_job_fin;

        if (emit) begin
            n_state  = seq_state;
            n_idx    = seq_idx;
            n_dsel   = seq_dsel;
            n_budget = step_last ? '0 : r_budget + BUDGET_W'(1);
            if (crc_en) begin
                n_crc = crc_update(crc_init ? CRC_INIT : r_crc, byte_out);
            end
            if (r_state == S_ZHDR) begin
                n_adler_lo   = 16'd1;
                n_adler_hi   = 16'd0;
                n_block_left = '0;
                n_raw_left   = i_geom.raw;
            end
            if (r_state == S_DATA && r_block_left == '0 && r_idx == 4'd4) begin
                n_block_left = blk_len;
            end
            if (data_en) begin
                n_adler_lo   = lo_next;
                n_adler_hi   = hi_next;
                n_block_left = r_block_left - BLOCK_LEN_W'(1);
                n_raw_left   = r_raw_left - RAW_W'(1);
            end
            if (closing) begin
                n_open = 1'b0;
            end
        end

        if (step_start) begin
            n_open   = 1'b1;
            n_budget = '0;
        end

        if (job_start) begin
            n_state   = sf ? S_SIG : S_DATA;
            n_idx     = '0;
            n_dsel    = (col0 == '0) ? D_FILTER : D_RED;
            n_job_pix = i_pix;
            n_job_fin = fin;
            n_col     = wrap ? '0 : col_inc[COUNT_W-1:0];
            n_row     = wrap ? row_inc[COUNT_W-1:0] : row0;
            n_phase   = fin ? PH_DONE : PH_STREAM;
        end

        if (i_abort) begin
            n_state  = S_IDLE;
            n_idx    = '0;
            n_open   = 1'b0;
            n_budget = '0;
            n_phase  = PH_START;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_idx        <= '0;
            r_dsel       <= D_FILTER;
            r_phase      <= PH_START;
            r_open       <= 1'b0;
            r_budget     <= '0;
            r_crc        <= CRC_INIT;
            r_adler_lo   <= 16'd1;
            r_adler_hi   <= 16'd0;
            r_block_left <= '0;
            r_raw_left   <= '0;
            r_col        <= '0;
            r_row        <= '0;
            r_job_fin    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_dsel       <= n_dsel;
            r_phase      <= n_phase;
            r_open       <= n_open;
            r_budget     <= n_budget;
            r_crc        <= n_crc;
            r_adler_lo   <= n_adler_lo;
            r_adler_hi   <= n_adler_hi;
            r_block_left <= n_block_left;
            r_raw_left   <= n_raw_left;
            r_col        <= n_col;
            r_row        <= n_row;
            r_job_fin    <= n_job_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job_pix <= n_job_pix;
    end

    assign o_pix_take     = step_start && !i_abort;
    assign o_beat_valid   = emit;
    assign o_beat.data    = byte_out;
    assign o_beat.last    = step_last;
    assign o_beat.eof     = eof;
    assign o_stat.step_open = r_open;
    assign o_stat.drop      = step_start && held;
    assign o_stat.job_fin   = r_job_fin;

endmodule

`default_nettype wire

/* verif/tb_top.sv */
// Self-checking testbench for png_stored_block_encoder_unit.
// Predicts every file byte from the pixels sent and checks each output transfer in order.
// Depends on pse_pkg and the encoder RTL only.
`timescale 1ns / 100ps

module tb_top
    import pse_pkg::*;
();

    localparam int          WATCHDOG_LIMIT = 2000;
    localparam logic [1:0]  CFG_SPARE_LO   = 2'd2;
    localparam logic [1:0]  CFG_SPARE_HI   = 2'd3;
    localparam int          BYTE_CAP       = 52;

    typedef struct {
        bit [7:0] data;
        bit       eof;
    } t_file_byte;

    typedef struct {
        bit [7:0] data;
        bit       last;
        bit       eof;
    } t_exp_beat;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_cfg_we    = 1'b0;
    logic [1:0]        i_cfg_idx   = '0;
    logic [DIM_W-1:0]  i_cfg_data  = '0;
    logic              i_in_valid  = 1'b0;
    logic [23:0]       i_pixel_rgb = '0;
    logic              i_out_stall = 1'b0;
    logic              o_in_stall;
    logic              o_out_valid;
    logic [7:0]        o_out_byte;
    logic              o_last_of_run;
    logic              o_end_of_file;

    png_stored_block_encoder_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_pixel_rgb   (i_pixel_rgb),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run),
        .o_end_of_file (o_end_of_file)
    );

    // encoder state as predicted
    bit [DIM_W-1:0] dim_w_reg;
    bit [DIM_W-1:0] dim_h_reg;
    bit [31:0]      run_crc;
    int unsigned    adler_lo;
    int unsigned    adler_hi;
    int unsigned    block_left;
    int unsigned    raw_left;
    int unsigned    col_idx;
    int unsigned    row_idx;
    int unsigned    file_phase;
    t_file_byte     run_bytes[$];
    t_file_byte     carry_bytes[$];
    t_exp_beat      expected_bytes[$];

    int error_count = 0;
    int burst_left  = 0;
    int idle_cycles = 0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    task automatic report(input string what);
        $display("mismatch @%0t: %s", $realtime, what);
        error_count++;
    endtask

    function automatic int unsigned clamp_dim(input bit [DIM_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_DIMENSION) return MAX_DIMENSION;
        return v;
    endfunction

    function automatic void emit(input bit [7:0] b, input bit eof);
        t_file_byte fb;
        fb.data = b;
        fb.eof  = eof;
        run_bytes.push_back(fb);
    endfunction

    function automatic void emit_crc(input bit [7:0] b);
        bit [31:0] c;
        c = run_crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
        run_crc = c;
        emit(b, 1'b0);
    endfunction

    function automatic void emit_word(input bit [31:0] v, input bit eof_last);
        emit(v[31:24], 1'b0);
        emit(v[23:16], 1'b0);
        emit(v[15:8], 1'b0);
        emit(v[7:0], eof_last);
    endfunction

    function automatic void emit_word_crc(input bit [31:0] v);
        emit_crc(v[31:24]);
        emit_crc(v[23:16]);
        emit_crc(v[15:8]);
        emit_crc(v[7:0]);
    endfunction

    function automatic void emit_chunk_type(input bit [31:0] t);
        run_crc = 32'hFFFFFFFF;
        emit_word_crc(t);
    endfunction

    function automatic void emit_raw(input bit [7:0] b);
        bit [31:0] len;
        if (block_left == 0) begin
            len = (raw_left > 65535) ? 65535 : raw_left;
            emit_crc((len == raw_left) ? 8'd1 : 8'd0);
            emit_crc(len[7:0]);
            emit_crc(len[15:8]);
            emit_crc(~len[7:0]);
            emit_crc(~len[15:8]);
            block_left = len;
        end
        emit_crc(b);
        adler_lo += b;
        if (adler_lo >= 65521) adler_lo -= 65521;
        adler_hi += adler_lo;
        if (adler_hi >= 65521) adler_hi -= 65521;
        if (block_left > 0) block_left--;
        if (raw_left > 0) raw_left--;
    endfunction

    function automatic void open_file();
        int unsigned w;
        int unsigned h;
        longint raw;
        longint nblk;
        w    = clamp_dim(dim_w_reg);
        h    = clamp_dim(dim_h_reg);
        raw  = (longint'(w) * 3 + 1) * h;
        nblk = (raw + 65534) / 65535;
        adler_lo   = 1;
        adler_hi   = 0;
        block_left = 0;
        raw_left   = 32'(raw);
        col_idx    = 0;
        row_idx    = 0;
        emit_word(32'h89504E47, 1'b0);
        emit_word(32'h0D0A1A0A, 1'b0);
        emit_word(32'd13, 1'b0);
        emit_chunk_type("IHDR");
        emit_word_crc(w);
        emit_word_crc(h);
        emit_crc(8'd8);
        emit_crc(8'd2);
        emit_crc(8'd0);
        emit_crc(8'd0);
        emit_crc(8'd0);
        emit_word(~run_crc, 1'b0);
        emit_word(32'(2 + raw + 5 * nblk + 4), 1'b0);
        emit_chunk_type("IDAT");
        emit_crc(8'h78);
        emit_crc(8'h01);
        file_phase = 1;
    endfunction

    function automatic void close_file();
        emit_word_crc({adler_hi[15:0], adler_lo[15:0]});
        emit_word(~run_crc, 1'b0);
        emit_word(32'd0, 1'b0);
        emit_chunk_type("IEND");
        emit_word(~run_crc, 1'b1);
        file_phase = 2;
    endfunction

    function automatic void predict_pixel(input bit [23:0] px);
        bit        had_carry;
        int        n;
        t_exp_beat ob;
        had_carry = carry_bytes.size() > 0;
        run_bytes = carry_bytes;
        carry_bytes.delete();
        if (!(had_carry && file_phase == 2)) begin
            if (file_phase != 1) open_file();
            if (col_idx == 0) emit_raw(8'd0);
            emit_raw(px[23:16]);
            emit_raw(px[15:8]);
            emit_raw(px[7:0]);
            col_idx++;
            if (col_idx >= clamp_dim(dim_w_reg)) begin
                col_idx = 0;
                row_idx++;
                if (row_idx >= clamp_dim(dim_h_reg)) close_file();
            end
        end
        n = (run_bytes.size() > BYTE_CAP) ? BYTE_CAP : run_bytes.size();
        for (int k = 0; k < run_bytes.size(); k++) begin
            if (k < n) begin
                ob.data = run_bytes[k].data;
                ob.eof  = run_bytes[k].eof;
                ob.last = (k + 1 == n);
                expected_bytes.push_back(ob);
            end else begin
                carry_bytes.push_back(run_bytes[k]);
            end
        end
    endfunction

    function automatic void reset_model();
        dim_w_reg  = 1;
        dim_h_reg  = 1;
        run_crc    = 32'hFFFFFFFF;
        adler_lo   = 1;
        adler_hi   = 0;
        block_left = 0;
        raw_left   = 0;
        col_idx    = 0;
        row_idx    = 0;
        file_phase = 0;
        carry_bytes.delete();
    endfunction

    task automatic send_pixel(input bit [23:0] px);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        i_in_valid  <= 1'b1;
        i_pixel_rgb <= px;
        do @(posedge i_clk); while (o_in_stall);
        predict_pixel(px);
        burst_left--;
    endtask

    task automatic drain_outputs();
        i_in_valid <= 1'b0;
        burst_left = 0;
        wait (expected_bytes.size() == 0);
        @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input bit [DIM_W-1:0] value);
        drain_outputs();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_WIDTH) dim_w_reg = value;
        else if (idx == CFG_HEIGHT) dim_h_reg = value;
        if (idx == CFG_WIDTH || idx == CFG_HEIGHT) begin
            file_phase = 0;
            carry_bytes.delete();
        end
    endtask

    task automatic set_dims(input bit [DIM_W-1:0] w, input bit [DIM_W-1:0] h);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
    endtask

    // 1x1 after reset: first transfer overflows, second only flushes, third restarts, fourth flushes
    task automatic test_reset_dims();
        send_pixel(24'h000000);
        send_pixel(24'hFFFFFF);
        send_pixel(24'h123456);
        send_pixel(24'hABCDEF);
    endtask

    task automatic test_zero_dims();
        set_dims('0, '0);
        repeat (3) send_pixel(24'($urandom));
    endtask

    task automatic test_pixel_bits();
        set_dims(3, 2);
        send_pixel(24'h000000);
        send_pixel(24'hFFFFFF);
        send_pixel(24'h555555);
        send_pixel(24'hAAAAAA);
        send_pixel(24'h0F0F0F);
        send_pixel(24'hF0F0F0);
    endtask

    task automatic test_spare_index();
        set_dims(3, 2);
        send_pixel(24'($urandom));
        send_pixel(24'($urandom));
        write_reg(CFG_SPARE_LO, '1);
        write_reg(CFG_SPARE_HI, 14'h0001);
        repeat (4) send_pixel(24'($urandom));
    endtask

    task automatic test_tall_abandon();
        set_dims(1, 14'h3FFF);
        repeat (40) send_pixel(24'($urandom));
    endtask

    // wide rows need two stored blocks: check the IDAT length and the first block header
    task automatic test_block_split();
        set_dims(14'h3FFF, 3);
        repeat (20) send_pixel(24'($urandom));
    endtask

    task automatic test_random_files();
        int sent;
        int w;
        int h;
        int n;
        sent = 0;
        while (sent < 380) begin
            w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
            h = $urandom_range(1, 5);
            set_dims(DIM_W'(w), DIM_W'(h));
            n = (w == 0 ? 1 : w) * h;
            case ($urandom_range(0, 9))
                0, 1:    n = $urandom_range(1, n);
                2:       n = n + $urandom_range(1, 3);
                default: ;
            endcase
            repeat (n) send_pixel(24'($urandom));
            sent += n;
        end
    endtask

    always @(posedge i_clk) begin
        t_exp_beat e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_bytes.size() == 0) begin
                report($sformatf("unexpected byte %02h", o_out_byte));
            end else begin
                e = expected_bytes.pop_front();
                if (o_out_byte !== e.data)
                    report($sformatf("out_byte %02h, want %02h", o_out_byte, e.data));
                if (o_last_of_run !== e.last)
                    report($sformatf("last_of_run %b, want %b", o_last_of_run, e.last));
                if (o_end_of_file !== e.eof)
                    report($sformatf("end_of_file %b, want %b", o_end_of_file, e.eof));
            end
        end
    end

    initial begin
        int mode;
        int run;
        run = 0;
        @(posedge i_rst_n);
        forever begin
            mode = $urandom_range(0, 2);
            repeat ($urandom_range(50, 300)) begin
                @(posedge i_clk);
                case (mode)
                    0: i_out_stall <= 1'b0;
                    1: i_out_stall <= ($urandom_range(0, 99) < 30);
                    default: begin
                        if (run > 0) begin
                            run--;
                        end else begin
                            i_out_stall <= ~i_out_stall;
                            run = $urandom_range(0, 12);
                        end
                    end
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        reset_model();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_dims();
        test_zero_dims();
        test_pixel_bits();
        test_spare_index();
        test_tall_abandon();
        test_block_split();
        test_random_files();
        drain_outputs();
        repeat (20) @(posedge i_clk);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* files.f */
hdl/pse_pkg.sv
hdl/pse_cfg.sv
hdl/pse_gen.sv
hdl/png_stored_block_encoder_unit.sv
verif/tb_top.sv
